### rtl/bfrs_pkg.sv
// shared types and constants for the bitmap free run search core
// no dependencies; imported by bfrs_word_eval and bitmap_free_run_search_core

package bfrs_pkg;

   localparam int REG_W     = 21;
   localparam int FOUND_W   = 20;
   localparam int IDX_W     = 14;
   localparam int DATA_W    = 64;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CL_W      = 22;
   localparam int MAX_BIT_W = 6;
   localparam int POP_W     = 7;

   localparam logic [REG_W-1:0] FOUND_LIMIT = 21'h100000;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_CLUSTERS = 2'd2;

   typedef struct packed {
      logic [CL_W-1:0]  base;
      logic [CL_W-1:0]  carry;
      logic [REG_W-1:0] want;
      logic [REG_W-1:0] limit;
      logic [REG_W-1:0] map_clusters;
      logic [REG_W-1:0] lo;
      logic [REG_W-1:0] hi;
   } bfrs_scan_type;

   typedef struct packed {
      logic                 hit;
      logic [MAX_BIT_W-1:0] hit_idx;
      logic [CL_W-1:0]      carry;
      logic [POP_W-1:0]     used_cnt;
   } bfrs_eval_type;

endpackage

### rtl/bfrs_store.sv
// bitmap word memory: one write port, one read port with registered data
// no package dependencies

module bfrs_store #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 64,
   parameter int AW    = 14
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bfrs_word_eval.sv
// evaluates one bitmap word: first-fit run detection with carry-in and used count
// depends on bfrs_pkg

module bfrs_word_eval
   import bfrs_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic [WORD_BITS-1:0] word,
   input  bfrs_scan_type        scan,
   output bfrs_eval_type        res
);

   localparam int IW = $clog2(WORD_BITS);
   localparam int CW = $clog2(WORD_BITS + 1);
   localparam int LV = IW;
   localparam int NG = (WORD_BITS + 7) / 8;

   function automatic logic [CW-1:0] rem_of(logic [CL_W-1:0] x, logic [CL_W-1:0] b);
      logic [CL_W-1:0] d;
      d = x - b;
      if (x <= b) return '0;
      if (d >= CL_W'(WORD_BITS)) return CW'(WORD_BITS);
      return CW'(d);
   endfunction

   logic [CW-1:0]        rem_lim, rem_map, rem_lo, rem_hi;
   logic [WORD_BITS-1:0] used, in_lim, cmask, hit_v;
   logic                 pv [LV+1][WORD_BITS];
   logic [IW-1:0]        pp [LV+1][WORD_BITS];
   logic [NG*8-1:0]      padded;
   logic [IW-1:0]        idx;
   logic [POP_W-1:0]     pop_total;

   assign rem_lim = rem_of({1'b0, scan.limit}, scan.base);
   assign rem_map = rem_of({1'b0, scan.map_clusters}, scan.base);
   assign rem_lo  = rem_of({1'b0, scan.lo}, scan.base);
   assign rem_hi  = rem_of({1'b0, scan.hi}, scan.base);

   always_comb begin
      for (int k = 0; k < WORD_BITS; k++) begin
         used[k]   = word[k] && (CW'(k) < rem_map);
         in_lim[k] = CW'(k) < rem_lim;
         cmask[k]  = used[k] && (CW'(k) >= rem_lo) && (CW'(k) < rem_hi);
      end
   end

   // last used position at or below each bit, log-depth prefix
   always_comb begin
      for (int k = 0; k < WORD_BITS; k++) begin
         pv[0][k] = used[k];
         pp[0][k] = IW'(k);
      end
      for (int l = 0; l < LV; l++) begin
         for (int k = 0; k < WORD_BITS; k++) begin
            if (!pv[l][k] && (k >= (1 << l))) begin
               pv[l+1][k] = pv[l][k - (1 << l)];
               pp[l+1][k] = pp[l][k - (1 << l)];
            end else begin
               pv[l+1][k] = pv[l][k];
               pp[l+1][k] = pp[l][k];
            end
         end
      end
   end

   always_comb begin
      logic [CL_W-1:0] run_k;
      for (int k = 0; k < WORD_BITS; k++) begin
         run_k = pv[LV][k] ? (CL_W'(k) - CL_W'(pp[LV][k])) : (scan.carry + CL_W'(k + 1));
         hit_v[k] = in_lim[k] && !used[k] && (run_k >= CL_W'(scan.want));
      end
   end

   always_comb begin
      idx = '0;
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (hit_v[k]) begin
            idx = IW'(k);
         end
      end
   end

   always_comb begin
      logic [3:0]       gs;
      logic [POP_W-1:0] total;
      padded = (NG*8)'(cmask);
      total  = '0;
      for (int g = 0; g < NG; g++) begin
         gs = '0;
         for (int b = 0; b < 8; b++) begin
            gs = gs + 4'(padded[g*8 + b]);
         end
         total = total + POP_W'(gs);
      end
      pop_total = total;
   end

   assign res.used_cnt = pop_total;
   assign res.hit      = |hit_v;
   assign res.hit_idx  = MAX_BIT_W'(idx);
   assign res.carry    = pv[LV][WORD_BITS-1]
                         ? (CL_W'(WORD_BITS - 1) - CL_W'(pp[LV][WORD_BITS-1]))
                         : (scan.carry + CL_W'(WORD_BITS));

endmodule

### rtl/bitmap_free_run_search_core.sv
// bitmap free run search core: loads and trivial queries answer in the cycle after acceptance
// find/count scan one word per cycle; one query at a time, busy high while scanning,
// the receiver cannot stall
// reset is synchronous: clears control state and config registers, not the bitmap
// depends on bfrs_pkg, bfrs_store, bfrs_word_eval

module bitmap_free_run_search_core
   import bfrs_pkg::*;
#(
   parameter int MAP_WORDS = 16384,
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [IDX_W-1:0]     req_word_index,
   input  logic [DATA_W-1:0]    req_word_data,
   input  logic [REG_W-1:0]     req_run_length,
   output logic                 rsp_valid,
   output logic                 rsp_status,
   output logic [FOUND_W-1:0]   rsp_found_start,
   output logic [REG_W-1:0]     rsp_used_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int ACW = AW + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic               find_ff, find_in;
   logic [REG_W-1:0]   want_ff, want_in;
   logic [REG_W-1:0]   bound_ff, bound_in;
   logic [ACW-1:0]     addr_ff, addr_in;
   logic [CL_W-1:0]    issue_base_ff, issue_base_in;
   logic               issue_on_ff, issue_on_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [CL_W-1:0]    proc_base_ff, proc_base_in;
   logic [CL_W-1:0]    carry_ff, carry_in;
   logic [REG_W-1:0]   cnt_ff, cnt_in;
   logic               hit_ff, hit_in;
   logic [CL_W-1:0]    pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0] rsp_found_ff, rsp_found_in;
   logic [REG_W-1:0]   rsp_used_ff, rsp_used_in;
   logic [REG_W-1:0]   ss_ff, se_ff, mc_ff;

   logic                 accept;
   logic                 wr_en;
   logic [WORD_BITS-1:0] rd_data;
   logic [REG_W-1:0]     limit_c, hi_c;
   bfrs_scan_type        scan;
   bfrs_eval_type        ev;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign wr_en     = accept && (req_func == FUNC_LOAD)
                      && (32'(req_word_index) < 32'(MAP_WORDS));

   assign limit_c = (ss_ff > FOUND_LIMIT) ? FOUND_LIMIT : ss_ff;
   assign hi_c    = (se_ff > mc_ff) ? mc_ff : se_ff;

   bfrs_store #(
      .DEPTH (MAP_WORDS),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_word_index)),
      .wr_data (req_word_data[WORD_BITS-1:0]),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      scan.base         = proc_base_ff;
      scan.carry        = carry_ff;
      scan.want         = want_ff;
      scan.limit        = bound_ff;
      scan.map_clusters = mc_ff;
      scan.lo           = ss_ff;
      scan.hi           = bound_ff;
   end

   bfrs_word_eval #(
      .WORD_BITS (WORD_BITS)
   ) u_eval (
      .word (rd_data),
      .scan (scan),
      .res  (ev)
   );

   always_comb begin
      logic [CL_W-1:0] avail;
      logic [CL_W-1:0] tsum;
      state_in      = state_ff;
      find_in       = find_ff;
      want_in       = want_ff;
      bound_in      = bound_ff;
      addr_in       = addr_ff;
      issue_base_in = issue_base_ff;
      issue_on_in   = issue_on_ff;
      rd_vld_in     = 1'b0;
      proc_base_in  = proc_base_ff;
      carry_in      = carry_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = 1'b0;
      rsp_found_in  = '0;
      rsp_used_in   = '0;
      avail         = issue_base_ff - carry_ff;
      tsum          = avail + CL_W'(want_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in       = '0;
               issue_base_in = '0;
               issue_on_in   = 1'b1;
               carry_in      = '0;
               cnt_in        = '0;
               hit_in        = 1'b0;
               want_in       = req_run_length;
               case (req_func)
                  FUNC_FIND: begin
                     find_in  = 1'b1;
                     bound_in = limit_c;
                     if (req_run_length == '0) begin
                        rsp_valid_in = 1'b1;
                     end else if (req_run_length > limit_c) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_COUNT: begin
                     find_in  = 1'b0;
                     bound_in = hi_c;
                     if (hi_c <= ss_ff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue_on_ff && (addr_ff < ACW'(MAP_WORDS))
                && (issue_base_ff < CL_W'(bound_ff))) begin
               rd_vld_in     = 1'b1;
               proc_base_in  = issue_base_ff;
               addr_in       = addr_ff + ACW'(1);
               issue_base_in = issue_base_ff + CL_W'(WORD_BITS);
            end else begin
               issue_on_in = 1'b0;
            end
            if (rd_vld_ff && find_ff && ev.hit) begin
               hit_in      = 1'b1;
               pos_in      = proc_base_ff + CL_W'(ev.hit_idx) + CL_W'(1);
               rd_vld_in   = 1'b0;
               issue_on_in = 1'b0;
               state_in    = ST_DONE;
            end else if (rd_vld_ff) begin
               carry_in = ev.carry;
               cnt_in   = cnt_ff + REG_W'(ev.used_cnt);
            end else if (!issue_on_ff) begin
               // past the end of the store every cluster reads free
               state_in = ST_DONE;
               if (find_ff && (tsum <= CL_W'(bound_ff))) begin
                  hit_in = 1'b1;
                  pos_in = tsum;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = find_ff && !hit_ff;
            rsp_found_in  = hit_ff ? FOUND_W'(pos_ff - CL_W'(want_ff)) : '0;
            rsp_used_in   = find_ff ? '0 : cnt_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_on_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ss_ff        <= '0;
         se_ff        <= '0;
         mc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         issue_on_ff  <= issue_on_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHRINK_START: ss_ff <= csr_wdata;
               CSR_SHRINK_END:   se_ff <= csr_wdata;
               CSR_MAP_CLUSTERS: mc_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      find_ff       <= find_in;
      want_ff       <= want_in;
      bound_ff      <= bound_in;
      addr_ff       <= addr_in;
      issue_base_ff <= issue_base_in;
      proc_base_ff  <= proc_base_in;
      carry_ff      <= carry_in;
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_start = rsp_found_ff;
   assign rsp_used_count  = rsp_used_ff;

endmodule
